@@ rtl/itws_pkg.sv @@
// shared constants, types and helpers for the tile window split block
`timescale 1ns / 1ps

package itws_pkg;

    // fixed field widths of the request
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int IN_TDATA_W = 32;

    // configuration register map
    localparam int REG_IDX_W = 4;
    localparam logic [REG_IDX_W-1:0] REG_X_BEGIN = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_END   = 4'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_BEGIN = 4'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_END   = 4'd3;

    // parameter defaults
    localparam int COORD_BITS_DEF = 14;
    localparam int MAX_TILES_DEF  = 4096;

    // shared unit operation
    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    // quotient bits the divider produces: enough for a coordinate or a tile row
    function automatic int quo_bits(input int coord_bits);
        return (coord_bits > IDX_W) ? coord_bits : IDX_W;
    endfunction

endpackage

@@ rtl/itws_muldiv.sv @@
// shared multiply and restoring divide unit
`timescale 1ns / 1ps

module itws_muldiv #(
    parameter int COORD_BITS = itws_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  itws_pkg::alu_req_t                     req,
    input  logic [COORD_BITS+itws_pkg::CNT_W-1:0]  opa,
    input  logic [itws_pkg::CNT_W-1:0]             opb,
    output logic                                   done,
    output logic [COORD_BITS+itws_pkg::CNT_W-1:0]  result,
    output logic [itws_pkg::CNT_W-1:0]             remainder
);
    import itws_pkg::*;

    localparam int DW = COORD_BITS + CNT_W;
    localparam int QB = quo_bits(COORD_BITS);
    localparam int CW = $clog2(QB + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          div_reg, div_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic [DW-1:0]    lo_reg, lo_next;

    logic [DW-1:0]    prod;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    assign prod  = DW'(opa[COORD_BITS-1:0]) * DW'(opb);
    assign trial = {rem_reg, lo_reg[QB-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        lo_next   = lo_reg;
        if (req.start)
        begin
            if (req.op == OP_MUL)
            begin
                lo_next   = prod;
                div_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                // high part is below the divisor, so QB steps give the full quotient
                rem_next  = CNT_W'(opa >> QB);
                lo_next   = DW'(opa[QB-1:0]);
                dvs_next  = opb;
                div_next  = 1'b1;
                cnt_next  = CW'(QB);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? CNT_W'(diff) : CNT_W'(trial);
            lo_next  = DW'({lo_reg[QB-2:0], ge});
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        lo_reg  <= lo_next;
    end

    assign done      = done_reg;
    assign result    = lo_reg;
    assign remainder = rem_reg;

    // a new operation is never issued over a running division
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("muldiv started while busy");

    // a finished division leaves a remainder below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg) |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

    // busy always has steps left to run
    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("busy with zero step count");

endmodule

@@ rtl/image_tile_window_split_top.sv @@
// top level of the tile window split block: registers, sequencer and stream ports
`timescale 1ns / 1ps

// usage
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the window registers
//   (0 x begin, 1 x end, 2 y begin, 3 y end); cfg_ready is always high,
//   unknown indexes are dropped. write only while the block is idle
//   s_* carries one request (tile index, tile count) per transfer
//   m_* returns one result per request: four tile bounds and an error flag
// timing
//   a bad request (zero count, index not below count, count above MAX_TILES,
//   inverted window) skips the arithmetic and goes straight to the output state
//   a good request runs a multiply, s (0..12) column halvings and a divide for
//   row and column, then a multiply and a divide per bound. the shared
//   multiply/divide unit runs five divisions of Q = max(COORD_BITS, 12)
//   quotient bits, one quotient bit a cycle
//   one request is in flight at a time; s_tready is high only when idle, so
//   the next transfer is taken in the cycle the result appears at the earliest
// reset
//   clears the window registers to zero, the sequencer to idle, m_tvalid low
// stall
//   the result sits in the output register until taken; the next request may
//   be accepted meanwhile but waits for that register before it is written

module image_tile_window_split_top #(
    parameter int COORD_BITS = itws_pkg::COORD_BITS_DEF,
    parameter int MAX_TILES  = itws_pkg::MAX_TILES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [itws_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    // request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [itws_pkg::IN_TDATA_W-1:0]      s_tdata,   // tile_index, tile_count, zero pad
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((4*COORD_BITS+8)/8)*8-1:0]    m_tdata    // tile_x_begin, tile_x_end,
                                                            // tile_y_begin, tile_y_end,
                                                            // bad_request, zero pad
);
    import itws_pkg::*;

    localparam int DW    = COORD_BITS + CNT_W;      // product / dividend width
    localparam int AW    = COORD_BITS + 1 + CNT_W;  // aspect compare width
    localparam int OUT_W = ((4 * COORD_BITS + 8) / 8) * 8;
    localparam int CMP_W = 32;

    typedef enum logic [6:0] {
        S_IDLE = 7'b000_0001,
        S_MULB = 7'b000_0010,
        S_LOOP = 7'b000_0100,
        S_DIVI = 7'b000_1000,
        S_MULK = 7'b001_0000,
        S_DIVK = 7'b010_0000,
        S_OUT  = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;

    // window registers
    logic [COORD_BITS-1:0] xb_reg, xb_next;
    logic [COORD_BITS-1:0] xe_reg, xe_next;
    logic [COORD_BITS-1:0] yb_reg, yb_next;
    logic [COORD_BITS-1:0] ye_reg, ye_next;

    // per-request working registers
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      nx_reg, nx_next;
    logic [CNT_W-1:0]      ny_reg, ny_next;
    logic [CNT_W-1:0]      col_reg, col_next;
    logic [CNT_W-1:0]      row_reg, row_next;
    logic [COORD_BITS-1:0] dx_reg, dx_next;
    logic [COORD_BITS-1:0] dy_reg, dy_next;
    logic [AW-1:0]         a_reg, a_next;       // 2*dx*ny
    logic [AW-1:0]         b_reg, b_next;       // dy*nx, later the bound product
    logic [1:0]            sel_reg, sel_next;   // bound being worked on
    logic                  pend_reg, pend_next;
    logic                  bad_reg, bad_next;
    logic [COORD_BITS-1:0] res_reg [4];
    logic [COORD_BITS-1:0] res_next [4];

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    // request fields and checks
    logic [IDX_W-1:0]      idx_in;
    logic [CNT_W-1:0]      cnt_in;
    logic [COORD_BITS-1:0] dx_in;
    logic [COORD_BITS-1:0] dy_in;
    logic                  bad_in;

    // shared unit hookup
    alu_req_t              alu_req;
    logic [DW-1:0]         alu_opa;
    logic [CNT_W-1:0]      alu_opb;
    logic                  alu_done;
    logic [DW-1:0]         alu_result;
    logic [CNT_W-1:0]      alu_rem;

    // current bound selection
    logic [CNT_W-1:0]      k_sel;
    logic [CNT_W-1:0]      n_sel;
    logic [COORD_BITS-1:0] ext_sel;
    logic [COORD_BITS-1:0] begin_sel;
    logic                  unit_wait;

    assign idx_in = s_tdata[IDX_W-1:0];
    assign cnt_in = s_tdata[IDX_W +: CNT_W];
    assign dx_in  = xe_reg - xb_reg;
    assign dy_in  = ye_reg - yb_reg;
    assign bad_in = (cnt_in == '0)
                 || (CNT_W'(idx_in) >= cnt_in)
                 || (CMP_W'(cnt_in) > CMP_W'(MAX_TILES))
                 || (xe_reg < xb_reg)
                 || (ye_reg < yb_reg);

    // sel[1] picks rows over columns, sel[0] picks the far edge
    assign k_sel     = (sel_reg[1] ? row_reg : col_reg) + CNT_W'(sel_reg[0]);
    assign n_sel     = sel_reg[1] ? ny_reg : nx_reg;
    assign ext_sel   = sel_reg[1] ? dy_reg : dx_reg;
    assign begin_sel = sel_reg[1] ? yb_reg : xb_reg;

    assign unit_wait = (state_reg == S_MULB) || (state_reg == S_DIVI)
                    || (state_reg == S_MULK) || (state_reg == S_DIVK);

    always_comb
    begin
        alu_req.start = unit_wait && !pend_reg;
        case (state_reg)
            S_MULB:
            begin
                alu_req.op = OP_MUL;
                alu_opa    = DW'(dy_reg);
                alu_opb    = nx_reg;
            end
            S_DIVI:
            begin
                alu_req.op = OP_DIV;
                alu_opa    = DW'(idx_reg);
                alu_opb    = nx_reg;
            end
            S_MULK:
            begin
                alu_req.op = OP_MUL;
                alu_opa    = DW'(ext_sel);
                alu_opb    = k_sel;
            end
            S_DIVK:
            begin
                alu_req.op = OP_DIV;
                alu_opa    = DW'(b_reg);
                alu_opb    = n_sel;
            end
            default:
            begin
                alu_req.op = OP_MUL;
                alu_opa    = '0;
                alu_opb    = '0;
            end
        endcase
    end

    itws_muldiv #(
        .COORD_BITS (COORD_BITS)
    ) u_muldiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (alu_req),
        .opa       (alu_opa),
        .opb       (alu_opb),
        .done      (alu_done),
        .result    (alu_result),
        .remainder (alu_rem)
    );

    always_comb
    begin
        state_next    = state_reg;
        xb_next       = xb_reg;
        xe_next       = xe_reg;
        yb_next       = yb_reg;
        ye_next       = ye_reg;
        idx_next      = idx_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        sel_next      = sel_reg;
        bad_next      = bad_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // unit handshake: one start per wait state, cleared on completion
        pend_next = pend_reg;
        if (alu_req.start)
        begin
            pend_next = 1'b1;
        end
        if (alu_done)
        begin
            pend_next = 1'b0;
        end

        // output register drains independently of the sequencer
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // window register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_X_BEGIN: xb_next = cfg_data;
                REG_X_END:   xe_next = cfg_data;
                REG_Y_BEGIN: yb_next = cfg_data;
                REG_Y_END:   ye_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next = idx_in;
                    nx_next  = cnt_in;
                    ny_next  = CNT_W'(1);
                    dx_next  = dx_in;
                    dy_next  = dy_in;
                    a_next   = AW'({dx_in, 1'b0});
                    sel_next = 2'd0;
                    bad_next = bad_in;
                    if (bad_in)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            res_next[i] = '0;
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MULB;
                    end
                end
            end
            S_MULB:
            begin
                if (alu_done)
                begin
                    b_next     = AW'(alu_result);
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                // halve columns while even and the tiles are too narrow
                if (!nx_reg[0] && (a_reg < b_reg))
                begin
                    nx_next = nx_reg >> 1;
                    ny_next = ny_reg << 1;
                    a_next  = a_reg << 1;
                    b_next  = b_reg >> 1;
                end
                else
                begin
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                if (alu_done)
                begin
                    row_next   = CNT_W'(alu_result);
                    col_next   = alu_rem;
                    state_next = S_MULK;
                end
            end
            S_MULK:
            begin
                if (alu_done)
                begin
                    b_next     = AW'(alu_result);
                    state_next = S_DIVK;
                end
            end
            S_DIVK:
            begin
                if (alu_done)
                begin
                    res_next[sel_reg] = begin_sel + COORD_BITS'(alu_result);
                    if (sel_reg == 2'd3)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_MULK;
                    end
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({bad_reg, res_reg[3], res_reg[2],
                                            res_reg[1], res_reg[0]});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            xb_reg       <= '0;
            xe_reg       <= '0;
            yb_reg       <= '0;
            ye_reg       <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            xb_reg       <= xb_next;
            xe_reg       <= xe_next;
            yb_reg       <= yb_next;
            ye_reg       <= ye_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        sel_reg     <= sel_next;
        bad_reg     <= bad_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // the shared unit only finishes while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> unit_wait)
        else $error("muldiv completion outside a wait state");

    // column count never reaches zero during the halving loop
    a_nx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> (nx_reg != '0))
        else $error("column count zero in halving loop");

    // a rejected request carries all-zero bounds
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[4*COORD_BITS])
            |-> (m_tdata_reg[4*COORD_BITS-1:0] == '0))
        else $error("bad request with non-zero bounds");

    // a served tile never has its far edge before its near edge
    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tdata_reg[4*COORD_BITS])
            |-> ((m_tdata_reg[COORD_BITS-1:0] <= m_tdata_reg[2*COORD_BITS-1:COORD_BITS])
              && (m_tdata_reg[3*COORD_BITS-1:2*COORD_BITS]
                  <= m_tdata_reg[4*COORD_BITS-1:3*COORD_BITS])))
        else $error("tile bounds out of order");

endmodule
